// ===== design/modexp_pkg.sv =====
// ----------------------------------------------------------------------------
// modexp_pkg
// Shared types and constants for the modular exponentiation block.
// ----------------------------------------------------------------------------
package modexp_pkg;

    localparam int unsigned MOD_W     = 30;
    localparam int unsigned MUL_CNT_W = $clog2(MOD_W + 1);

    localparam logic [MOD_W-1:0] PRIME_MOD    = 30'd998244353;
    localparam logic [MOD_W+1:0] PRIME_MOD_X1 = 32'd998244353;
    localparam logic [MOD_W+1:0] PRIME_MOD_X2 = 32'd1996488706;

    typedef logic [MOD_W-1:0] residue_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SQUARE,
        ST_MULT,
        ST_OUT
    } me_state_t;

    typedef struct packed {
        logic     start;
        residue_t op_a;
        residue_t op_b;
    } mm_req_t;

    typedef struct packed {
        logic     done;
        residue_t product;
    } mm_rsp_t;

endpackage

// ===== design/modular_exponentiation.sv =====
// ----------------------------------------------------------------------------
// modular_exponentiation
// base^exponent mod 998244353 by left-to-right square-and-multiply.
// ----------------------------------------------------------------------------
// One item at a time. The exponent is scanned MSB first; each leading zero
// bit costs a scan step, and after the first one bit every bit costs a square
// on the bit-serial multiplier plus a scan step, and every one bit a further
// multiply. The result sits in an output register, so a new transfer is
// taken while the previous result waits on m_ready.
module modular_exponentiation
    import modexp_pkg::*;
#(
    parameter int unsigned EXP_BITS = 63
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [29:0]         s_base,
    input  logic [EXP_BITS-1:0] s_exponent,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [29:0]         m_power_mod
);

    localparam int unsigned CNT_W = $clog2(EXP_BITS + 1);

    me_state_t              state_reg,   state_next;
    residue_t               base_reg,    base_next;
    residue_t               acc_reg,     acc_next;
    logic [EXP_BITS-1:0]    exp_reg,     exp_next;
    logic [CNT_W-1:0]       cnt_reg,     cnt_next;
    logic                   started_reg, started_next;
    logic                   m_valid_reg, m_valid_next;
    residue_t               m_data_reg,  m_data_next;

    mm_req_t                mm_req;
    mm_rsp_t                mm_rsp;
    logic                   cur_bit;

    modexp_mulmod u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mm_req),
        .rsp     (mm_rsp)
    );

    assign cur_bit = exp_reg[EXP_BITS-1];

    always_comb begin
        state_next   = state_reg;
        base_next    = base_reg;
        acc_next     = acc_reg;
        exp_next     = exp_reg;
        cnt_next     = cnt_reg;
        started_next = started_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        mm_req       = '{start: 1'b0, op_a: acc_reg, op_b: acc_reg};
        s_ready      = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    base_next    = (s_base >= PRIME_MOD) ? s_base - PRIME_MOD : s_base;
                    exp_next     = s_exponent;
                    cnt_next     = CNT_W'(EXP_BITS);
                    acc_next     = residue_t'(1);
                    started_next = 1'b0;
                    state_next   = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (cnt_reg == '0) begin
                    state_next = ST_OUT;
                end else if (started_reg) begin
                    mm_req.start = 1'b1;
                    state_next   = ST_SQUARE;
                end else begin
                    if (cur_bit) begin
                        acc_next     = base_reg;
                        started_next = 1'b1;
                    end
                    exp_next = exp_reg << 1;
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_SQUARE: begin
                if (mm_rsp.done) begin
                    acc_next = mm_rsp.product;
                    if (cur_bit) begin
                        mm_req     = '{start: 1'b1, op_a: mm_rsp.product, op_b: base_reg};
                        state_next = ST_MULT;
                    end else begin
                        exp_next   = exp_reg << 1;
                        cnt_next   = cnt_reg - 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_MULT: begin
                if (mm_rsp.done) begin
                    acc_next   = mm_rsp.product;
                    exp_next   = exp_reg << 1;
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = acc_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
            started_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            cnt_reg     <= cnt_next;
            started_reg <= started_next;
        end
        base_reg   <= base_next;
        acc_reg    <= acc_next;
        exp_reg    <= exp_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_power_mod = m_data_reg;

endmodule

// ===== design/modexp_mulmod.sv =====
// ----------------------------------------------------------------------------
// modexp_mulmod
// Bit-serial interleaved modular multiplier, one multiplier bit per cycle,
// MSB first: r = 2r + b_i*a, reduced below the prime after every step.
// ----------------------------------------------------------------------------
module modexp_mulmod
    import modexp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  mm_req_t req,
    output mm_rsp_t rsp
);

    residue_t               a_reg,    a_next;
    residue_t               b_reg,    b_next;
    residue_t               r_reg,    r_next;
    logic [MUL_CNT_W-1:0]   cnt_reg,  cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;

    logic [MOD_W+1:0]       sum;
    logic [MOD_W+1:0]       red;

    always_comb begin
        sum = {1'b0, r_reg, 1'b0} + {2'b00, (b_reg[MOD_W-1] ? a_reg : residue_t'(0))};
        if (sum >= PRIME_MOD_X2) begin
            red = sum - PRIME_MOD_X2;
        end else if (sum >= PRIME_MOD_X1) begin
            red = sum - PRIME_MOD_X1;
        end else begin
            red = sum;
        end
    end

    always_comb begin
        a_next    = a_reg;
        b_next    = b_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            a_next    = req.op_a;
            b_next    = req.op_b;
            r_next    = '0;
            cnt_next  = MUL_CNT_W'(MOD_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            r_next   = red[MOD_W-1:0];
            b_next   = b_reg << 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == MUL_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        a_reg <= a_next;
        b_reg <= b_next;
        r_reg <= r_next;
    end

    assign rsp.done    = done_reg;
    assign rsp.product = r_reg;

endmodule

// ===== tb/tb_modular_exponentiation.sv =====
// ----------------------------------------------------------------------------
// tb_modular_exponentiation
// Self-checking testbench for the modular exponentiation block.
// ----------------------------------------------------------------------------
// A scoreboard computes base^exponent mod 998244353 by its own square-and-
// multiply for every input transfer and checks each result transfer in order.
// Directed corner items come first, then random items with mostly short
// exponents and a few full-width ones. Both sides idle in random bursts,
// except in alternate phases of the random items and in the final stretch.
`timescale 1ns / 1ps

module tb_modular_exponentiation;
    import modexp_pkg::*;

    localparam int unsigned EXP_W          = 63;
    localparam int unsigned N_RANDOM       = 1600;
    localparam int unsigned QUIET_TAIL     = 200;
    localparam int unsigned IDLE_PHASE     = 200;
    localparam int unsigned WATCHDOG_LIMIT = 20000;
    localparam int unsigned DRAIN_CYCLES   = 64;
    localparam logic [29:0] BASE_MAX       = 30'h3FFF_FFFF;
    localparam logic [EXP_W-1:0] EXP_ONES  = {EXP_W{1'b1}};

    class power_scoreboard;
        typedef struct {
            logic [29:0]      base;
            logic [EXP_W-1:0] exponent;
            residue_t         power_mod;
            int unsigned      seq;
        } pending_power_t;

        pending_power_t pending_powers[$];
        int unsigned    error_count;
        int unsigned    inputs_noted;
        int unsigned    results_checked;
        int unsigned    zero_exponents;
        int unsigned    wide_exponents;
        int unsigned    reduced_bases;

        function residue_t predict_power_mod(logic [29:0] base, logic [EXP_W-1:0] exponent);
            bit [63:0] modulus;
            bit [63:0] b;
            bit [63:0] acc;
            modulus = 64'(PRIME_MOD);
            b       = 64'(base) % modulus;
            acc     = 64'd1;
            for (int i = EXP_W - 1; i >= 0; i--) begin
                acc = (acc * acc) % modulus;
                if (exponent[i]) begin
                    acc = (acc * b) % modulus;
                end
            end
            return residue_t'(acc);
        endfunction

        function void note_input(logic [29:0] base, logic [EXP_W-1:0] exponent);
            pending_power_t p;
            p.base      = base;
            p.exponent  = exponent;
            p.power_mod = predict_power_mod(base, exponent);
            p.seq       = inputs_noted;
            pending_powers.push_back(p);
            inputs_noted++;
            if (exponent == '0) zero_exponents++;
            if (exponent[EXP_W-1:40] != '0) wide_exponents++;
            if (base >= 30'(PRIME_MOD)) reduced_bases++;
        endfunction

        task report(string msg);
            error_count++;
            $display("MISMATCH %0d at %0t: %s", error_count, $realtime, msg);
        endtask

        task check_result(residue_t power_mod);
            pending_power_t p;
            if (pending_powers.size() == 0) begin
                report($sformatf("result %0d with no input waiting", power_mod));
                return;
            end
            p = pending_powers.pop_front();
            results_checked++;
            if (power_mod !== p.power_mod) begin
                report($sformatf("transfer %0d base %0d exponent 0x%h: got %0d, want %0d",
                                 p.seq, p.base, p.exponent, power_mod, p.power_mod));
            end
        endtask

        function int unsigned pending_count();
            return pending_powers.size();
        endfunction
    endclass

    logic             aclk = 1'b0;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    logic [29:0]      s_base;
    logic [EXP_W-1:0] s_exponent;
    logic             m_valid;
    logic             m_ready;
    logic [29:0]      m_power_mod;

    power_scoreboard sb;
    logic            allow_idle;
    logic            quiet_tail;
    int unsigned     stall_left;
    int unsigned     idle_cycles;

    always #6 aclk = ~aclk;

    modular_exponentiation #(
        .EXP_BITS(EXP_W)
    ) i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_base     (s_base),
        .s_exponent (s_exponent),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_power_mod(m_power_mod)
    );

    // Result side: check on transfer, then decide m_ready for the next edge.
    always @(posedge aclk) begin
        if (m_valid === 1'b1 && m_ready === 1'b1) begin
            sb.check_result(m_power_mod);
        end
        if (!allow_idle || quiet_tail) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 3) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid === 1'b1 && s_ready === 1'b1) || (m_valid === 1'b1 && m_ready === 1'b1)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                         idle_cycles, sb.pending_count());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic send_power_item(input logic [29:0] base, input logic [EXP_W-1:0] exponent);
        int unsigned gap;
        gap = 0;
        if (allow_idle && !quiet_tail && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_base     <= base;
        s_exponent <= exponent;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        sb.note_input(base, exponent);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_count() != 0) @(posedge aclk);
    endtask

    function automatic logic [29:0] random_base();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0: begin
                case ($urandom_range(0, 2))
                    0:       return 30'd0;
                    1:       return 30'd1;
                    default: return 30'(PRIME_MOD) - 30'd1;
                endcase
            end
            1:       return 30'($urandom_range(32'(PRIME_MOD), 32'(BASE_MAX)));
            default: return 30'($urandom_range(0, 32'(PRIME_MOD) - 1));
        endcase
    endfunction

    // Mostly short exponents keep the run short; a few use the full width.
    function automatic logic [EXP_W-1:0] random_exponent();
        int unsigned pick;
        int unsigned w;
        bit [63:0]   raw;
        pick = $urandom_range(0, 99);
        raw  = {$urandom, $urandom};
        if (pick < 3) begin
            return raw[EXP_W-1:0];
        end
        if (pick < 18) begin
            w = $urandom_range(11, 24);
        end else begin
            w = $urandom_range(0, 10);
        end
        raw = raw & ((64'd1 << w) - 64'd1);
        return raw[EXP_W-1:0];
    endfunction

    initial begin
        logic [29:0] prime_base;
        prime_base = 30'(PRIME_MOD);
        sb         = new();
        stall_left  = 0;
        idle_cycles = 0;
        aresetn    <= 1'b0;
        s_valid    <= 1'b0;
        s_base     <= '0;
        s_exponent <= '0;
        m_ready    <= 1'b0;
        allow_idle <= 1'b1;
        quiet_tail <= 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_power_item(30'd0, '0);
        send_power_item(prime_base - 30'd1, '0);
        send_power_item(BASE_MAX, '0);
        send_power_item(prime_base, '0);
        send_power_item(30'd0, 63'd1);
        send_power_item(30'd1, EXP_ONES);
        send_power_item(30'd2, 63'd1);
        send_power_item(30'd2, 63'd29);
        send_power_item(prime_base - 30'd1, 63'd2);
        send_power_item(prime_base - 30'd1, 63'd3);
        send_power_item(prime_base, 63'd5);
        send_power_item(BASE_MAX, 63'd3);
        send_power_item(prime_base + 30'd1, EXP_ONES);
        send_power_item(30'd3, 63'd1 << (EXP_W - 1));
        send_power_item(30'd0, 63'd1 << (EXP_W - 1));
        send_power_item(30'd12345, 63'(PRIME_MOD) - 63'd1);
        send_power_item(prime_base - 30'd2, 63'(PRIME_MOD) - 63'd2);
        send_power_item(30'd5, 63'h5555_5555_5555_5555);
        send_power_item(30'd7, 63'h2AAA_AAAA_AAAA_AAAA);
        send_power_item(BASE_MAX, EXP_ONES);
        drain_results();

        for (int unsigned n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 2) begin
                drain_results();
            end
            allow_idle <= ((n / IDLE_PHASE) % 2) == 0;
            quiet_tail <= (n >= N_RANDOM - QUIET_TAIL);
            send_power_item(random_base(), random_exponent());
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d input transfers, %0d results checked, %0d mismatches",
                 sb.inputs_noted, sb.results_checked, sb.error_count);
        $display("  %0d zero exponents, %0d exponents above 2^40, %0d bases at or over the modulus",
                 sb.zero_exponents, sb.wide_exponents, sb.reduced_bases);
        if (sb.error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
